// ===== hw/rtl/cia402_drive_state_machine_unit_defines.svh =====
// ----------------------------------------------------------------------------
// CiA402 drive state machine unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIA402_DRIVE_STATE_MACHINE_UNIT_DEFINES_SVH
`define CIA402_DRIVE_STATE_MACHINE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cdsm_pkg.sv =====
// ----------------------------------------------------------------------------
// CiA402 drive state machine package
// Types, widths, command masks and state codes shared by the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cdsm_pkg;

    localparam int CwWidth    = 16;
    localparam int PosWidth   = 32;
    localparam int ModeWidth  = 8;
    localparam int StepWidth  = 31;
    localparam int StateWidth = 3;

    localparam int CfgIndexWidth = 8;
    localparam int CfgDataWidth  = 32;

    localparam logic [CfgIndexWidth-1:0] RegProfilePositionMode = 8'd0;
    localparam logic [CfgIndexWidth-1:0] RegCountsPerStep       = 8'd1;
    localparam logic [CfgIndexWidth-1:0] RegVelocityInputEnable = 8'd2;
    localparam logic [CfgIndexWidth-1:0] RegModeEchoEnable      = 8'd3;

    localparam logic [StateWidth-1:0] StNotReady      = 3'd0;
    localparam logic [StateWidth-1:0] StSwOnDisabled  = 3'd1;
    localparam logic [StateWidth-1:0] StReady         = 3'd2;
    localparam logic [StateWidth-1:0] StSwitchedOn    = 3'd3;
    localparam logic [StateWidth-1:0] StOpEnabled     = 3'd4;
    localparam logic [StateWidth-1:0] StQuickStop     = 3'd5;
    localparam logic [StateWidth-1:0] StFaultReaction = 3'd6;
    localparam logic [StateWidth-1:0] StFault         = 3'd7;

    localparam logic [7:0] MaskShutdown  = 8'h87;
    localparam logic [7:0] CodeShutdown  = 8'h06;
    localparam logic [7:0] MaskSwitchOn  = 8'h8F;
    localparam logic [7:0] CodeSwitchOn  = 8'h07;
    localparam logic [7:0] MaskDisableV  = 8'h82;
    localparam logic [7:0] CodeDisableV  = 8'h00;
    localparam logic [7:0] MaskEnableOp  = 8'h8F;
    localparam logic [7:0] CodeEnableOp  = 8'h0F;
    localparam logic [7:0] MaskQuickStop = 8'h86;
    localparam logic [7:0] CodeQuickStop = 8'h02;

    localparam logic [CwWidth-1:0] SwRemote        = 16'h0200;
    localparam logic [CwWidth-1:0] SwVoltage       = 16'h0010;
    localparam logic [CwWidth-1:0] SwSetPointAck   = 16'h1000;
    localparam logic [CwWidth-1:0] SwTargetReached = 16'h0400;
    localparam logic [CwWidth-1:0] SwOpEnabledBase = 16'h0027;

    localparam int CwNewSetPointBit = 4;
    localparam int SwAckBit         = 12;

    localparam logic                 ResetProfilePositionMode = 1'b0;
    localparam logic [StepWidth-1:0] ResetCountsPerStep       = 31'd1;
    localparam logic                 ResetVelocityInputEnable = 1'b1;
    localparam logic                 ResetModeEchoEnable      = 1'b1;

    typedef struct packed {
        logic                 profile_position_mode;
        logic [StepWidth-1:0] step_size;
        logic                 velocity_input_enable;
        logic                 mode_echo_enable;
    } cfg_t;

    typedef struct packed {
        logic [CwWidth-1:0]   controlword;
        logic [PosWidth-1:0]  target_position;
        logic [PosWidth-1:0]  commanded_velocity;
        logic [ModeWidth-1:0] mode_of_operation;
    } in_item_t;

    typedef struct packed {
        logic [CwWidth-1:0]   statusword;
        logic [PosWidth-1:0]  actual_position;
        logic [PosWidth-1:0]  velocity_actual;
        logic [ModeWidth-1:0] mode_display;
    } out_item_t;

    function automatic logic [CwWidth-1:0] state_base_bits(input logic [StateWidth-1:0] st);
        logic [CwWidth-1:0] bits;
        case (st)
            StNotReady:      bits = 16'h0000;
            StSwOnDisabled:  bits = 16'h0040;
            StReady:         bits = 16'h0021;
            StSwitchedOn:    bits = 16'h0023;
            StOpEnabled:     bits = SwOpEnabledBase;
            StQuickStop:     bits = 16'h0007;
            StFaultReaction: bits = 16'h000F;
            StFault:         bits = 16'h0008;
            default:         bits = 16'h0000;
        endcase
        return bits;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cdsm_ifs.sv =====
// ----------------------------------------------------------------------------
// CiA402 drive state machine channel interfaces
// Valid/ready channels for bus cycles, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdsm_in_if;
    logic                           valid;
    logic                           ready;
    logic [cdsm_pkg::CwWidth-1:0]   controlword;
    logic [cdsm_pkg::PosWidth-1:0]  target_position;
    logic [cdsm_pkg::PosWidth-1:0]  commanded_velocity;
    logic [cdsm_pkg::ModeWidth-1:0] mode_of_operation;

    modport source (output valid, controlword, target_position, commanded_velocity,
                    mode_of_operation, input ready);
    modport sink (input valid, controlword, target_position, commanded_velocity,
                  mode_of_operation, output ready);
endinterface

interface cdsm_out_if;
    logic                           valid;
    logic                           ready;
    logic [cdsm_pkg::CwWidth-1:0]   statusword;
    logic [cdsm_pkg::PosWidth-1:0]  actual_position;
    logic [cdsm_pkg::PosWidth-1:0]  velocity_actual;
    logic [cdsm_pkg::ModeWidth-1:0] mode_display;

    modport source (output valid, statusword, actual_position, velocity_actual,
                    mode_display, input ready);
    modport sink (input valid, statusword, actual_position, velocity_actual,
                  mode_display, output ready);
endinterface

interface cdsm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [cdsm_pkg::CfgIndexWidth-1:0] index;
    logic [cdsm_pkg::CfgDataWidth-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cdsm_cfg.sv =====
// ----------------------------------------------------------------------------
// CiA402 drive state machine configuration registers
// Holds the four control registers written over the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cdsm_cfg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    cdsm_cfg_if.sink            cfg,
    output cdsm_pkg::cfg_t      cfg_regs
);
    import cdsm_pkg::*;

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.profile_position_mode <= ResetProfilePositionMode;
            cfg_reg.step_size             <= ResetCountsPerStep;
            cfg_reg.velocity_input_enable <= ResetVelocityInputEnable;
            cfg_reg.mode_echo_enable      <= ResetModeEchoEnable;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                RegProfilePositionMode: cfg_reg.profile_position_mode <= cfg.data[0];
                RegCountsPerStep:       cfg_reg.step_size <= cfg.data[StepWidth-1:0];
                RegVelocityInputEnable: cfg_reg.velocity_input_enable <= cfg.data[0];
                RegModeEchoEnable:      cfg_reg.mode_echo_enable <= cfg.data[0];
                default:                ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cdsm_core.sv =====
// ----------------------------------------------------------------------------
// CiA402 drive state machine core
// Device state, set-point handshake and position state, with the result
// of each bus cycle computed in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cdsm_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire cdsm_pkg::in_item_t  item,
    input  wire cdsm_pkg::cfg_t      cfg_regs,
    output cdsm_pkg::out_item_t      result
);
    import cdsm_pkg::*;

    logic [StateWidth-1:0] state_reg;
    logic [StateWidth-1:0] state_next;
    logic [CwWidth-1:0]    last_cw_reg;
    logic [PosWidth-1:0]   target_reg;
    logic [PosWidth-1:0]   target_next;
    logic [PosWidth-1:0]   position_reg;
    logic [PosWidth-1:0]   position_next;
    logic                  ack_reg;
    logic                  ack_next;

    logic [7:0]          cw_low;
    logic                cmd_shutdown;
    logic                cmd_sw_on;
    logic                cmd_disable_v;
    logic                cmd_en_op;
    logic                cmd_q_stop;
    logic                op;
    logic                pp;
    logic                b4;
    logic                pb4;
    logic [PosWidth:0]   cur_x;
    logic [PosWidth:0]   tgt_x;
    logic                up;
    logic [PosWidth:0]   distance;
    logic                reach;
    logic [PosWidth-1:0] chase_pos;
    logic [CwWidth-1:0]  sw;

    assign cw_low        = item.controlword[7:0];
    assign cmd_shutdown  = (cw_low & MaskShutdown) == CodeShutdown;
    assign cmd_sw_on     = (cw_low & MaskSwitchOn) == CodeSwitchOn;
    assign cmd_disable_v = (cw_low & MaskDisableV) == CodeDisableV;
    assign cmd_en_op     = (cw_low & MaskEnableOp) == CodeEnableOp;
    assign cmd_q_stop    = (cw_low & MaskQuickStop) == CodeQuickStop;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            StNotReady:
            begin
                state_next = StSwOnDisabled;
            end
            StSwOnDisabled:
            begin
                if (cmd_shutdown)
                    state_next = StReady;
            end
            StReady:
            begin
                if (cmd_sw_on)
                    state_next = StSwitchedOn;
                else if (cmd_disable_v)
                    state_next = StSwOnDisabled;
            end
            StSwitchedOn:
            begin
                if (cmd_en_op)
                    state_next = StOpEnabled;
                else if (cmd_shutdown)
                    state_next = StReady;
                else if (cmd_disable_v)
                    state_next = StSwOnDisabled;
            end
            StOpEnabled:
            begin
                if (cmd_q_stop)
                    state_next = StQuickStop;
                else if (cmd_sw_on)
                    state_next = StSwitchedOn;
                else if (cmd_shutdown)
                    state_next = StReady;
                else if (cmd_disable_v)
                    state_next = StSwOnDisabled;
            end
            StQuickStop:
            begin
                state_next = cmd_en_op ? StOpEnabled : StSwOnDisabled;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    assign op  = state_next == StOpEnabled;
    assign pp  = cfg_regs.profile_position_mode;
    assign b4  = item.controlword[CwNewSetPointBit];
    assign pb4 = last_cw_reg[CwNewSetPointBit];

    always_comb
    begin
        target_next = target_reg;
        ack_next    = ack_reg;
        if (pp && op)
        begin
            if (b4 && !pb4)
            begin
                target_next = item.target_position;
                ack_next    = 1'b1;
            end
            else if (!b4 && pb4)
            begin
                ack_next = 1'b0;
            end
        end
        else
        begin
            ack_next = 1'b0;
        end
    end

    // The step is clamped to the remaining distance, so the chase lands on
    // the target and never wraps.
    assign cur_x    = {position_reg[PosWidth-1], position_reg};
    assign tgt_x    = {target_next[PosWidth-1], target_next};
    assign up       = $signed(cur_x) < $signed(tgt_x);
    assign distance = up ? (tgt_x - cur_x) : (cur_x - tgt_x);
    assign reach    = {2'b00, cfg_regs.step_size} >= distance;

    always_comb
    begin
        if (reach)
            chase_pos = target_next;
        else if (up)
            chase_pos = position_reg + {1'b0, cfg_regs.step_size};
        else
            chase_pos = position_reg - {1'b0, cfg_regs.step_size};
    end

    always_comb
    begin
        position_next = position_reg;
        if (op)
        begin
            if (pp)
                position_next = chase_pos;
            else if (cfg_regs.velocity_input_enable)
                position_next = position_reg + item.commanded_velocity;
        end
    end

    always_comb
    begin
        sw = state_base_bits(state_next) | SwRemote;
        if (state_next != StSwOnDisabled && state_next != StNotReady)
            sw = sw | SwVoltage;
        if (ack_next)
            sw = sw | SwSetPointAck;
        if (op && pp && position_next == target_next)
            sw = sw | SwTargetReached;
    end

    assign result.statusword      = sw;
    assign result.actual_position = position_next;
    assign result.velocity_actual = position_next - position_reg;
    assign result.mode_display    = cfg_regs.mode_echo_enable ? item.mode_of_operation
                                                              : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= StNotReady;
            last_cw_reg  <= '0;
            target_reg   <= '0;
            position_reg <= '0;
            ack_reg      <= 1'b0;
        end
        else if (advance)
        begin
            state_reg    <= state_next;
            last_cw_reg  <= item.controlword;
            target_reg   <= target_next;
            position_reg <= position_next;
            ack_reg      <= ack_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cia402_drive_state_machine_unit.sv =====
// ----------------------------------------------------------------------------
// CiA402 drive state machine unit
// Runs the CiA402 device state machine and a simple motion model on one
// process-data cycle per transfer.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the request channel is one bus cycle: controlword,
// target position, commanded velocity and mode byte. Each one yields exactly
// one transfer on the response channel with the statusword, actual position,
// per-cycle position change and displayed mode, in the same order.
// The cfg channel writes the four control registers; it is always ready and
// is meant to be used only while no bus cycle is in flight.
// A bus cycle is captured in an input register, processed in one pass into
// the result register, and offered on the response channel from there. One
// transfer per clock is sustained unless the receiver stalls; the single
// combinational pass from input register to result register sets that rate.
// When the receiver stalls, the result register holds its transfer and the
// input register holds one more, after which request.ready drops.
// Reset brings the drive to not ready to switch on, clears position, target
// and acknowledge, and loads the register defaults; both channels are empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cia402_drive_state_machine_unit_defines.svh"

module cia402_drive_state_machine_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cdsm_cfg_if.sink    cfg,
    cdsm_in_if.sink     request,
    cdsm_out_if.source  response
);
    import cdsm_pkg::*;

    cfg_t      cfg_regs;
    logic      stage_valid_reg;
    in_item_t  stage_item_reg;
    logic      rsp_valid_reg;
    out_item_t rsp_item_reg;
    out_item_t result;
    logic      advance;
    logic      take;

    cdsm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    cdsm_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (stage_item_reg),
        .cfg_regs (cfg_regs),
        .result   (result)
    );

    assign advance       = stage_valid_reg && (!rsp_valid_reg || response.ready);
    assign request.ready = !stage_valid_reg || advance;
    assign take          = request.valid && request.ready;

    assign response.valid           = rsp_valid_reg;
    assign response.statusword      = rsp_item_reg.statusword;
    assign response.actual_position = rsp_item_reg.actual_position;
    assign response.velocity_actual = rsp_item_reg.velocity_actual;
    assign response.mode_display    = rsp_item_reg.mode_display;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (response.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg.controlword        <= request.controlword;
            stage_item_reg.target_position    <= request.target_position;
            stage_item_reg.commanded_velocity <= request.commanded_velocity;
            stage_item_reg.mode_of_operation  <= request.mode_of_operation;
        end
        if (advance)
            rsp_item_reg <= result;
    end

    `CDSM_ASSERT_NEXT(a_take_fills_stage, take, stage_valid_reg,
        "accepted bus cycle did not reach the input register")
    `CDSM_ASSERT_NEXT(a_advance_fills_result, advance, response.valid,
        "processed bus cycle did not reach the result register")
    `CDSM_ASSERT_SAME(a_ack_only_enabled,
        response.valid && response.statusword[SwAckBit],
        response.statusword[6:0] == (SwOpEnabledBase[6:0] | SwVoltage[6:0]),
        "set-point acknowledge outside operation enabled")

endmodule

`default_nettype wire
